>>> src/tmcw_pkg.sv
// ---------------------------------------------------------------------------
// tmcw_pkg
// Shared types, field widths and character codes of the text console writer.
// ---------------------------------------------------------------------------
package tmcw_pkg;

  // default screen geometry
  localparam int DEF_COLS = 80;
  localparam int DEF_ROWS = 25;

  // payload widths
  localparam int CMD_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int TGT_W   = 8;
  localparam int RADDR_W = 11;
  localparam int POS_W   = 11;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int CELL_W  = 16;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 1'd1;
  localparam logic [CFG_DATA_W-1:0] FG_RESET = 4'hF;
  localparam logic [CFG_DATA_W-1:0] BG_RESET = 4'h0;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  // cell value after reset: space on attribute 0x0F
  localparam logic [CELL_W-1:0] INIT_CELL = 16'h0F20;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_SET   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } tmcw_cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_FILL,
    ST_FINISH
  } tmcw_state_t;

  // controller to datapath
  typedef struct packed {
    logic in_take;
    logic exec;
    logic cnt_clr;
    logic cnt_inc;
    logic init_wr;
    logic fill_wr;
    logic scroll_op;
    logic scroll_set;
    logic out_load;
  } tmcw_ctrl_t;

  // datapath to controller
  typedef struct packed {
    tmcw_cmd_t cmd;
    logic      scroll_need;
    logic      fill_end;
    logic      scroll_end;
    logic      out_free;
  } tmcw_stat_t;

endpackage

>>> src/tmcw_in_if.sv
// ---------------------------------------------------------------------------
// tmcw_in_if
// Command channel of the console writer: valid, ready and the command beat.
// ---------------------------------------------------------------------------
interface tmcw_in_if;
  logic                                valid;
  logic                                ready;
  logic [tmcw_pkg::CMD_W-1:0]          cmd;
  logic [tmcw_pkg::CHAR_W-1:0]         char_code;
  logic signed [tmcw_pkg::TGT_W-1:0]   target_col;
  logic signed [tmcw_pkg::TGT_W-1:0]   target_row;
  logic [tmcw_pkg::RADDR_W-1:0]        read_address;

  modport source (
    output valid, cmd, char_code, target_col, target_row, read_address,
    input  ready
  );
  modport sink (
    input  valid, cmd, char_code, target_col, target_row, read_address,
    output ready
  );
endinterface

>>> src/tmcw_out_if.sv
// ---------------------------------------------------------------------------
// tmcw_out_if
// Result channel of the console writer: valid, ready and the result beat.
// ---------------------------------------------------------------------------
interface tmcw_out_if;
  logic                          valid;
  logic                          ready;
  logic [tmcw_pkg::POS_W-1:0]    cursor_position;
  logic [tmcw_pkg::COL_W-1:0]    cursor_col;
  logic [tmcw_pkg::ROW_W-1:0]    cursor_row;
  logic [tmcw_pkg::CELL_W-1:0]   cell_value;
  logic                          did_scroll;

  modport source (
    output valid, cursor_position, cursor_col, cursor_row, cell_value, did_scroll,
    input  ready
  );
  modport sink (
    input  valid, cursor_position, cursor_col, cursor_row, cell_value, did_scroll,
    output ready
  );
endinterface

>>> src/tmcw_ram.sv
// ---------------------------------------------------------------------------
// tmcw_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module tmcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/tmcw_datapath.sv
// ---------------------------------------------------------------------------
// tmcw_datapath
// Cursor, color registers, text buffer RAM, sweep counter and result register.
// ---------------------------------------------------------------------------
module tmcw_datapath #(
  parameter int COLS = tmcw_pkg::DEF_COLS,
  parameter int ROWS = tmcw_pkg::DEF_ROWS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tmcw_pkg::tmcw_ctrl_t                 ctrl,
  output tmcw_pkg::tmcw_stat_t                 stat,
  input  logic [tmcw_pkg::CMD_W-1:0]           in_cmd,
  input  logic [tmcw_pkg::CHAR_W-1:0]          in_char_code,
  input  logic signed [tmcw_pkg::TGT_W-1:0]    in_target_col,
  input  logic signed [tmcw_pkg::TGT_W-1:0]    in_target_row,
  input  logic [tmcw_pkg::RADDR_W-1:0]         in_read_address,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [tmcw_pkg::POS_W-1:0]           out_cursor_position,
  output logic [tmcw_pkg::COL_W-1:0]           out_cursor_col,
  output logic [tmcw_pkg::ROW_W-1:0]           out_cursor_row,
  output logic [tmcw_pkg::CELL_W-1:0]          out_cell_value,
  output logic                                 out_did_scroll,
  input  logic                                 cfg_we,
  input  logic [tmcw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tmcw_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CNTW  = $clog2(CELLS + 1);
  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(ROWS);

  // latched command beat
  tmcw_pkg::tmcw_cmd_t                 cmd_r;
  logic [tmcw_pkg::CHAR_W-1:0]         char_r;
  logic signed [tmcw_pkg::TGT_W-1:0]   tcol_r;
  logic signed [tmcw_pkg::TGT_W-1:0]   trow_r;
  logic [tmcw_pkg::RADDR_W-1:0]        raddr_r;
  logic                                scroll_r;

  // cursor and colors
  logic [CW-1:0]                       col_r, col_nxt, col_put, col_clamp, wcol;
  logic [RW-1:0]                       row_r, row_nxt, row_put, row_clamp;
  logic [tmcw_pkg::CFG_DATA_W-1:0]     fg_r, bg_r;
  logic [tmcw_pkg::CELL_W-1:0]         blank_cell, put_cell;
  logic                                put_we, advance, scroll_need, addr_ok;

  // sweep counter
  logic [CNTW-1:0]                     cnt_r;

  // ram ports
  logic                                wr_en, rd_en;
  logic [AW-1:0]                       wr_addr, rd_addr, put_addr;
  logic [tmcw_pkg::CELL_W-1:0]         wr_data, rd_data;

  // result register
  logic                                out_valid_r;
  logic [tmcw_pkg::POS_W-1:0]          pos_r;
  logic [tmcw_pkg::COL_W-1:0]          ocol_r;
  logic [tmcw_pkg::ROW_W-1:0]          orow_r;
  logic [tmcw_pkg::CELL_W-1:0]         cell_r;
  logic                                oscroll_r;

  assign blank_cell = {bg_r, fg_r, tmcw_pkg::CH_SPACE};
  assign addr_ok    = 32'(raddr_r) < CELLS;

  // capture command beat
  always_ff @(posedge clk) begin
    if (ctrl.in_take) begin
      cmd_r   <= tmcw_pkg::tmcw_cmd_t'(in_cmd);
      char_r  <= in_char_code;
      tcol_r  <= in_target_col;
      trow_r  <= in_target_row;
      raddr_r <= in_read_address;
    end
  end

  // scroll flag of the current beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_r <= 1'b0;
    end else if (ctrl.in_take) begin
      scroll_r <= 1'b0;
    end else if (ctrl.scroll_set) begin
      scroll_r <= 1'b1;
    end
  end

  // color registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= tmcw_pkg::FG_RESET;
      bg_r <= tmcw_pkg::BG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tmcw_pkg::REG_FOREGROUND: fg_r <= cfg_wdata;
        tmcw_pkg::REG_BACKGROUND: bg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // put character: cursor motion and cell write
  always_comb begin
    col_put     = col_r;
    row_put     = row_r;
    wcol        = col_r;
    put_we      = 1'b0;
    advance     = 1'b0;
    scroll_need = 1'b0;
    case (char_r)
      tmcw_pkg::CH_NEWLINE: begin
        col_put = '0;
        advance = 1'b1;
      end
      tmcw_pkg::CH_RETURN: begin
        col_put = '0;
      end
      tmcw_pkg::CH_BACKSPACE: begin
        if (col_r != '0) begin
          col_put = col_r - 1'b1;
          wcol    = col_r - 1'b1;
          put_we  = 1'b1;
        end
      end
      default: begin
        put_we = 1'b1;
        if (col_r == CW'(COLS - 1)) begin
          col_put = '0;
          advance = 1'b1;
        end else begin
          col_put = col_r + 1'b1;
        end
      end
    endcase
    if (advance) begin
      if (row_r == RW'(ROWS - 1)) begin
        scroll_need = 1'b1;
      end else begin
        row_put = row_r + 1'b1;
      end
    end
  end

  assign put_addr = AW'(32'(row_r) * COLS) + AW'(wcol);
  assign put_cell = (char_r == tmcw_pkg::CH_BACKSPACE) ? blank_cell : {bg_r, fg_r, char_r};

  // set cursor: clamp each coordinate
  always_comb begin
    if (tcol_r[tmcw_pkg::TGT_W-1]) begin
      col_clamp = '0;
    end else if (32'(tcol_r[tmcw_pkg::TGT_W-2:0]) >= COLS) begin
      col_clamp = CW'(COLS - 1);
    end else begin
      col_clamp = CW'(tcol_r[tmcw_pkg::TGT_W-2:0]);
    end
    if (trow_r[tmcw_pkg::TGT_W-1]) begin
      row_clamp = '0;
    end else if (32'(trow_r[tmcw_pkg::TGT_W-2:0]) >= ROWS) begin
      row_clamp = RW'(ROWS - 1);
    end else begin
      row_clamp = RW'(trow_r[tmcw_pkg::TGT_W-2:0]);
    end
  end

  // cursor next value
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (ctrl.exec) begin
      case (cmd_r)
        tmcw_pkg::CMD_PUT: begin
          col_nxt = col_put;
          row_nxt = row_put;
        end
        tmcw_pkg::CMD_SET: begin
          col_nxt = col_clamp;
          row_nxt = row_clamp;
        end
        tmcw_pkg::CMD_CLEAR: begin
          col_nxt = '0;
          row_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // sweep counter for reset, clear and scroll
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctrl.cnt_clr) begin
      cnt_r <= '0;
    end else if (ctrl.cnt_inc) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // ram port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_r[AW-1:0];
    wr_data = blank_cell;
    rd_en   = 1'b0;
    rd_addr = AW'(raddr_r);
    if (ctrl.init_wr) begin
      wr_en   = 1'b1;
      wr_data = tmcw_pkg::INIT_CELL;
    end else if (ctrl.fill_wr) begin
      wr_en = 1'b1;
    end else if (ctrl.scroll_op) begin
      // read a row below, write what came back in the following cycle
      rd_en   = 32'(cnt_r) < CELLS - COLS;
      rd_addr = AW'(32'(cnt_r) + COLS);
      wr_en   = cnt_r != '0;
      wr_addr = AW'(cnt_r - 1'b1);
      wr_data = (32'(cnt_r) <= CELLS - COLS) ? rd_data : blank_cell;
    end else if (ctrl.exec) begin
      wr_en   = (cmd_r == tmcw_pkg::CMD_PUT) && put_we;
      wr_addr = put_addr;
      wr_data = put_cell;
      rd_en   = (cmd_r == tmcw_pkg::CMD_READ) && addr_ok;
    end
  end

  tmcw_ram #(
    .WIDTH(tmcw_pkg::CELL_W),
    .DEPTH(CELLS)
  ) u_tmcw_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      pos_r     <= tmcw_pkg::POS_W'(32'(row_nxt) * COLS + 32'(col_nxt));
      ocol_r    <= tmcw_pkg::COL_W'(col_nxt);
      orow_r    <= tmcw_pkg::ROW_W'(row_nxt);
      cell_r    <= (cmd_r == tmcw_pkg::CMD_READ && addr_ok) ? rd_data : '0;
      oscroll_r <= scroll_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cursor_position = pos_r;
  assign out_cursor_col      = ocol_r;
  assign out_cursor_row      = orow_r;
  assign out_cell_value      = cell_r;
  assign out_did_scroll      = oscroll_r;

  // status to the controller
  assign stat.cmd         = cmd_r;
  assign stat.scroll_need = scroll_need;
  assign stat.fill_end    = cnt_r == CNTW'(CELLS - 1);
  assign stat.scroll_end  = cnt_r == CNTW'(CELLS);
  assign stat.out_free    = !out_valid_r || out_ready;

endmodule

>>> src/tmcw_ctrl.sv
// ---------------------------------------------------------------------------
// tmcw_ctrl
// Sequencer of the console writer: accepts beats, runs sweeps, loads results.
// ---------------------------------------------------------------------------
module tmcw_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tmcw_pkg::tmcw_stat_t stat,
  output tmcw_pkg::tmcw_ctrl_t ctrl
);

  tmcw_pkg::tmcw_state_t state_r, state_nxt;

  // state register, reset starts the buffer clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tmcw_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    in_ready  = 1'b0;
    case (state_r)
      tmcw_pkg::ST_INIT: begin
        ctrl.init_wr = 1'b1;
        ctrl.cnt_inc = 1'b1;
        if (stat.fill_end) begin
          ctrl.cnt_clr = 1'b1;
          state_nxt    = tmcw_pkg::ST_IDLE;
        end
      end
      tmcw_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.in_take = 1'b1;
          state_nxt    = tmcw_pkg::ST_EXEC;
        end
      end
      tmcw_pkg::ST_EXEC: begin
        ctrl.exec = 1'b1;
        case (stat.cmd)
          tmcw_pkg::CMD_PUT, tmcw_pkg::CMD_SET: begin
            if (stat.cmd == tmcw_pkg::CMD_PUT && stat.scroll_need) begin
              ctrl.scroll_set = 1'b1;
              ctrl.cnt_clr    = 1'b1;
              state_nxt       = tmcw_pkg::ST_SCROLL;
            end else if (stat.out_free) begin
              ctrl.out_load = 1'b1;
              state_nxt     = tmcw_pkg::ST_IDLE;
            end else begin
              state_nxt = tmcw_pkg::ST_FINISH;
            end
          end
          tmcw_pkg::CMD_CLEAR: begin
            ctrl.cnt_clr = 1'b1;
            state_nxt    = tmcw_pkg::ST_FILL;
          end
          default: begin
            // read issued here, data ready next cycle
            state_nxt = tmcw_pkg::ST_FINISH;
          end
        endcase
      end
      tmcw_pkg::ST_SCROLL: begin
        ctrl.scroll_op = 1'b1;
        ctrl.cnt_inc   = 1'b1;
        if (stat.scroll_end) begin
          ctrl.cnt_clr = 1'b1;
          state_nxt    = tmcw_pkg::ST_FINISH;
        end
      end
      tmcw_pkg::ST_FILL: begin
        ctrl.fill_wr = 1'b1;
        ctrl.cnt_inc = 1'b1;
        if (stat.fill_end) begin
          ctrl.cnt_clr = 1'b1;
          state_nxt    = tmcw_pkg::ST_FINISH;
        end
      end
      tmcw_pkg::ST_FINISH: begin
        if (stat.out_free) begin
          ctrl.out_load = 1'b1;
          state_nxt     = tmcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tmcw_pkg::ST_INIT;
      end
    endcase
  end

endmodule

>>> src/text_mode_console_writer_unit.sv
// ---------------------------------------------------------------------------
// text_mode_console_writer_unit
// Text console writer: COLS x ROWS buffer of attribute/character cells.
// ---------------------------------------------------------------------------
// Usage:
//   in_chan carries one command beat (put, set cursor, clear, read cell);
//   out_chan returns exactly one result beat per command, in order.
//   cfg_we/cfg_index/cfg_wdata set the foreground and background colors;
//   write them only while no command is in flight.
// Sequence from the accepting edge to the edge that loads the result:
//   put (no scroll) and set cursor: EXEC, one buffer write at most
//   read cell: EXEC issues the registered RAM read, FINISH loads it
//   clear: EXEC, FILL with one cell written per cycle, FINISH
//   put that scrolls: EXEC, SCROLL with one cell moved per cycle, FINISH
//   after the load, the next beat is taken in IDLE
// Reset: a clearing pass over all COLS*ROWS cells fills the buffer with a space
//   on attribute 0x0F; in_chan.ready stays low until it ends.
// Stall: the result register holds a beat until out_chan.ready; one more
//   command is accepted meanwhile and waits to load its result.
// ---------------------------------------------------------------------------
module text_mode_console_writer_unit #(
  parameter int COLS = tmcw_pkg::DEF_COLS,
  parameter int ROWS = tmcw_pkg::DEF_ROWS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  tmcw_in_if.sink                          in_chan,
  tmcw_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [tmcw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tmcw_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  tmcw_pkg::tmcw_ctrl_t ctrl;
  tmcw_pkg::tmcw_stat_t stat;

  // sequencer
  tmcw_ctrl u_tmcw_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_chan.valid),
    .in_ready(in_chan.ready),
    .stat    (stat),
    .ctrl    (ctrl)
  );

  // cursor, buffer and result register
  tmcw_datapath #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_tmcw_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctrl               (ctrl),
    .stat               (stat),
    .in_cmd             (in_chan.cmd),
    .in_char_code       (in_chan.char_code),
    .in_target_col      (in_chan.target_col),
    .in_target_row      (in_chan.target_row),
    .in_read_address    (in_chan.read_address),
    .out_ready          (out_chan.ready),
    .out_valid          (out_chan.valid),
    .out_cursor_position(out_chan.cursor_position),
    .out_cursor_col     (out_chan.cursor_col),
    .out_cursor_row     (out_chan.cursor_row),
    .out_cell_value     (out_chan.cell_value),
    .out_did_scroll     (out_chan.did_scroll),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

endmodule

>>> src/tmcw_checker.sv
// ---------------------------------------------------------------------------
// tmcw_checker
// Port-level checks of the console writer, bound to the top level.
// ---------------------------------------------------------------------------
module tmcw_checker #(
  parameter int COLS = tmcw_pkg::DEF_COLS,
  parameter int ROWS = tmcw_pkg::DEF_ROWS
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [tmcw_pkg::COL_W-1:0]     cursor_col,
  input logic [tmcw_pkg::ROW_W-1:0]     cursor_row,
  input logic                           did_scroll
);

  // no command taken right after reset, as the clearing pass begins
  a_reset_not_ready: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("command channel ready right after reset");

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // reported column always lies on the screen
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(cursor_col) < COLS)
    else $error("cursor column beyond the row");

  // a scroll leaves the cursor at the start of the bottom row
  a_scroll_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && did_scroll |->
      cursor_col == '0 && cursor_row == tmcw_pkg::ROW_W'(ROWS - 1))
    else $error("scroll with cursor off the bottom row start");

endmodule

bind text_mode_console_writer_unit tmcw_checker #(
  .COLS(COLS),
  .ROWS(ROWS)
) u_tmcw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .cursor_col(out_chan.cursor_col),
  .cursor_row(out_chan.cursor_row),
  .did_scroll(out_chan.did_scroll)
);
